// ===== rtl/core/kbrd_pkg.sv =====
package kbrd_pkg;

  localparam int MAX_KMER    = 32;
  localparam int MAX_HASHES  = 8;
  localparam int FILTER_BITS = 1048576;
  localparam int NUM_PARTS   = 4;

  localparam logic [63:0] MUL_M = 64'hc6a4a7935bd1e995;
  localparam int          SHR_R = 47;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTS   = 3'd4;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
  localparam logic [OP_W-1:0] OP_BASE       = 5'd2;
  localparam logic [OP_W-1:0] OP_EXTRACT    = 5'd3;
  localparam logic [OP_W-1:0] OP_CANON      = 5'd4;
  localparam logic [OP_W-1:0] OP_PART_NEXT  = 5'd5;
  localparam logic [OP_W-1:0] OP_SEED_CLR   = 5'd6;
  localparam logic [OP_W-1:0] OP_H_LEN      = 5'd7;
  localparam logic [OP_W-1:0] OP_H_SEED     = 5'd8;
  localparam logic [OP_W-1:0] OP_X_BLK      = 5'd9;
  localparam logic [OP_W-1:0] OP_X_SHR      = 5'd10;
  localparam logic [OP_W-1:0] OP_H_XOR      = 5'd11;
  localparam logic [OP_W-1:0] OP_H_BNEXT    = 5'd12;
  localparam logic [OP_W-1:0] OP_H_TAIL     = 5'd13;
  localparam logic [OP_W-1:0] OP_H_RES      = 5'd14;
  localparam logic [OP_W-1:0] OP_H_SHR      = 5'd15;
  localparam logic [OP_W-1:0] OP_H_RES_SHR  = 5'd16;
  localparam logic [OP_W-1:0] OP_MOD_START  = 5'd17;
  localparam logic [OP_W-1:0] OP_MEM_RD     = 5'd18;
  localparam logic [OP_W-1:0] OP_PART_HIT   = 5'd19;
  localparam logic [OP_W-1:0] OP_SEED_NEXT  = 5'd20;
  localparam logic [OP_W-1:0] OP_EMIT       = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            mul_start;
    logic            mul_src_x;
  } cmd_t;

  typedef struct packed {
    logic trig;
    logic last;
    logic canon_done;
    logic part_done;
    logic part_hit;
    logic blk_more;
    logic rem_nz;
    logic mul_done;
    logic mod_done;
    logic probe_bit;
    logic seed_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/kbrd_in_if.sv =====
interface kbrd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  partition;
  logic [13:0] word_index;
  logic [63:0] word_data;
  logic [7:0]  base;
  logic        last_base;

  modport source (output valid, action, partition, word_index, word_data, base, last_base,
                  input ready);
  modport sink (input valid, action, partition, word_index, word_data, base, last_base,
                output ready);
endinterface

// ===== rtl/core/kbrd_out_if.sv =====
interface kbrd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_id;
  logic [3:0]  hit_mask;
  logic        unmatched;

  modport source (output valid, read_id, hit_mask, unmatched, input ready);
  modport sink (input valid, read_id, hit_mask, unmatched, output ready);
endinterface

// ===== rtl/core/kmer_bloom_read_dispatch.sv =====
// k-mer Bloom filter read dispatcher.
// The item channel carries two kinds of beat. A load beat (action 0) writes one
// 64-bit word into the filter memory of a partition. A base beat (action 1)
// shifts one read byte into the window; when it completes a window, the window
// is made canonical and hashed with MurmurHash64A under each seed, the hash is
// reduced modulo filter_bits and the filter bit is fetched.
// Each window runs a canonical compare and a pass over the partitions, and each
// probed bit runs a seed step, one step per 8-byte block, a tail step when
// kmer_len is not a multiple of 8 and a finish step on the shared 32x32
// multiplier, then the bit-serial modulo.
// The item channel takes a beat only while the controller is idle, so one item
// ends before the next begins.
// The last base of a read delivers one result beat (read_id, hit_mask,
// unmatched) into an output register. If the receiver stalls, the result is
// held, and only the next read's last base waits for it to drain.
// Synchronous reset restores the register defaults and clears the read state;
// the filter memory is not cleared and must be loaded before it is probed.
// Configuration writes are taken at any cycle and are meant for idle periods.
module kmer_bloom_read_dispatch (
  input  logic                             clk,
  input  logic                             rst,
  kbrd_in_if.sink                          item,
  kbrd_out_if.source                       result,
  input  logic                             cfg_we,
  input  logic [kbrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kbrd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kbrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences every step; the datapath owns all storage.
  kbrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_action (item.action),
    .in_ready  (item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kbrd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .partition  (item.partition),
    .word_index (item.word_index),
    .word_data  (item.word_data),
    .base       (item.base),
    .last_base  (item.last_base),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .read_id    (result.read_id),
    .hit_mask   (result.hit_mask),
    .unmatched  (result.unmatched)
  );

endmodule

// ===== rtl/core/kbrd_mul.sv =====
module kbrd_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  output logic        done,
  output logic [63:0] res
);
  import kbrd_pkg::*;

  // Low 64 bits of a * MUL_M from three 32x32 partial products.
  logic        busy;
  logic [1:0]  cnt;
  logic [63:0] prod;
  logic [31:0] op_a;
  logic [31:0] op_b;

  always_comb begin
    unique case (cnt)
      2'd0: begin
        op_a = a[31:0];
        op_b = MUL_M[31:0];
      end
      2'd1: begin
        op_a = a[31:0];
        op_b = MUL_M[63:32];
      end
      default: begin
        op_a = a[63:32];
        op_b = MUL_M[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (cnt != 2'd3) begin
        prod <= {32'd0, op_a} * {32'd0, op_b};
      end
      unique case (cnt)
        2'd0:    res <= res;
        2'd1:    res <= prod;
        default: res <= res + {prod[31:0], 32'd0};
      endcase
    end
  end

endmodule

// ===== rtl/core/kbrd_mod.sv =====
module kbrd_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [20:0] divisor,
  output logic        done,
  output logic [19:0] rem
);

  // Restoring remainder, one dividend bit per cycle.
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] sh;
  logic [20:0] r;
  logic [21:0] rr;
  logic [21:0] red;

  assign rr  = {r, sh[63]};
  assign red = (rr >= {1'b0, divisor}) ? rr - {1'b0, divisor} : rr;
  assign rem = r[19:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      r  <= 21'd0;
    end else if (busy) begin
      sh <= {sh[62:0], 1'b0};
      r  <= red[20:0];
    end
  end

endmodule

// ===== rtl/core/kbrd_dp.sv =====
module kbrd_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  kbrd_pkg::cmd_t                     cmd,
  output kbrd_pkg::sts_t                     sts,
  input  logic                               cfg_we,
  input  logic [kbrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kbrd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]                         partition,
  input  logic [13:0]                        word_index,
  input  logic [63:0]                        word_data,
  input  logic [7:0]                         base,
  input  logic                               last_base,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [31:0]                        read_id,
  output logic [3:0]                         hit_mask,
  output logic                               unmatched
);
  import kbrd_pkg::*;

  function automatic logic [7:0] comp(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h41:   r = 8'h54;
      8'h43:   r = 8'h47;
      8'h47:   r = 8'h43;
      8'h54:   r = 8'h41;
      default: r = 8'h4e;
    endcase
    return r;
  endfunction

  logic [5:0]  kmer_len;
  logic [5:0]  kmer_step;
  logic [3:0]  num_hashes;
  logic [20:0] filter_bits;
  logic [2:0]  num_partitions;

  logic [5:0]  k_c;
  logic [5:0]  step_c;
  logic [3:0]  nh_c;
  logic [20:0] fb_c;
  logic [2:0]  np_c;

  logic [7:0]  wb [MAX_KMER];
  logic [7:0]  w  [MAX_KMER];
  logic [7:0]  swp [MAX_KMER];
  logic        span [MAX_KMER];
  logic [31:0] pos;
  logic [31:0] nws;
  logic        trig;
  logic        last;
  logic [4:0]  p;
  logic [2:0]  part;
  logic [3:0]  seed;
  logic [2:0]  b;
  logic [3:0]  hits;
  logic [31:0] rcnt;
  logic [63:0] h;
  logic [63:0] x;
  logic        msrc;
  logic [63:0] rdata;
  logic [63:0] mem [1 << 16];

  logic [7:0]  ub;
  logic        trig_next;
  logic [5:0]  kk1;
  logic [4:0]  half;
  logic [5:0]  mir;
  logic [7:0]  ca;
  logic [7:0]  cc;
  logic        canon_done;
  logic [2:0]  nblk;
  logic [63:0] blk;
  logic [63:0] tl;
  logic [63:0] mres;
  logic        mdone;
  logic        mod_done;
  logic [19:0] idx;

  // Registers are saturated into their legal range where they are used.
  always_comb begin
    k_c    = (kmer_len == 6'd0) ? 6'd1 :
             (kmer_len > 6'(MAX_KMER)) ? 6'(MAX_KMER) : kmer_len;
    step_c = (kmer_step == 6'd0) ? 6'd1 : (kmer_step > 6'd32) ? 6'd32 : kmer_step;
    nh_c   = (num_hashes == 4'd0) ? 4'd1 :
             (num_hashes > 4'(MAX_HASHES)) ? 4'(MAX_HASHES) : num_hashes;
    fb_c   = (filter_bits == 21'd0) ? 21'd1 :
             (filter_bits > 21'(FILTER_BITS)) ? 21'(FILTER_BITS) : filter_bits;
    np_c   = (num_partitions == 3'd0) ? 3'd1 :
             (num_partitions > 3'(NUM_PARTS)) ? 3'(NUM_PARTS) : num_partitions;
  end

  assign ub = (base >= 8'h61 && base <= 8'h7a) ? base - 8'd32 : base;
  assign trig_next = (pos + 32'd1) == (nws + {26'd0, k_c});

  assign kk1  = k_c - 6'd1;
  assign half = kk1[5:1];
  assign mir  = kk1 - {1'b0, p};
  assign ca   = w[p];
  assign cc   = comp(w[mir[4:0]]);
  assign canon_done = (ca != cc) || (p >= half);

  assign nblk = k_c[5:3];

  always_comb begin
    for (int j = 0; j < MAX_KMER; j++) begin
      span[j] = (6'(j) >= {1'b0, p}) && (6'(j) <= mir);
      swp[j]  = comp(w[5'(kk1 - 6'(j))]);
    end
    for (int j = 0; j < 8; j++) begin
      blk[8*j +: 8] = w[{b[1:0], 3'(j)}];
      tl[8*j +: 8]  = (3'(j) < k_c[2:0]) ? w[{nblk[1:0], 3'(j)}] : 8'd0;
    end
  end

  kbrd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (msrc ? x : h),
    .done  (mdone),
    .res   (mres)
  );

  kbrd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_MOD_START),
    .dividend (h),
    .divisor  (fb_c),
    .done     (mod_done),
    .rem      (idx)
  );

  always_comb begin
    sts.trig       = trig;
    sts.last       = last;
    sts.canon_done = canon_done;
    sts.part_done  = part >= np_c;
    sts.part_hit   = hits[part[1:0]];
    sts.blk_more   = b < nblk;
    sts.rem_nz     = k_c[2:0] != 3'd0;
    sts.mul_done   = mdone;
    sts.mod_done   = mod_done;
    sts.probe_bit  = rdata[~idx[5:0]];
    sts.seed_last  = (seed + 4'd1) >= nh_c;
    sts.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem[{partition, word_index}] <= word_data;
    end
    if (cmd.op == OP_MEM_RD) begin
      rdata <= mem[{part[1:0], idx[19:6]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len       <= 6'd25;
      kmer_step      <= 6'd1;
      num_hashes     <= 4'd3;
      filter_bits    <= 21'(FILTER_BITS);
      num_partitions <= 3'd1;
      pos            <= 32'd0;
      nws            <= 32'd0;
      trig           <= 1'b0;
      last           <= 1'b0;
      p              <= 5'd0;
      part           <= 3'd0;
      seed           <= 4'd0;
      b              <= 3'd0;
      hits           <= 4'd0;
      rcnt           <= 32'd0;
      msrc           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KMER_LEN:    kmer_len       <= cfg_data[5:0];
          CFG_KMER_STEP:   kmer_step      <= cfg_data[5:0];
          CFG_NUM_HASHES:  num_hashes     <= cfg_data[3:0];
          CFG_FILTER_BITS: filter_bits    <= cfg_data;
          CFG_NUM_PARTS:   num_partitions <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.mul_start) begin
        msrc <= cmd.mul_src_x;
      end
      // A new result may be loaded in the cycle the previous one is taken.
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_BASE: begin
          pos  <= pos + 32'd1;
          trig <= trig_next;
          last <= last_base;
        end
        OP_EXTRACT: begin
          p    <= 5'd0;
          part <= 3'd0;
          nws  <= nws + {26'd0, step_c};
        end
        OP_CANON: begin
          if (!canon_done) begin
            p <= p + 5'd1;
          end
        end
        OP_PART_NEXT: part <= part + 3'd1;
        OP_SEED_CLR:  seed <= 4'd0;
        OP_H_SEED:    b    <= 3'd0;
        OP_H_BNEXT:   b    <= b + 3'd1;
        OP_PART_HIT: begin
          hits[part[1:0]] <= 1'b1;
          part            <= part + 3'd1;
        end
        OP_SEED_NEXT: seed <= seed + 4'd1;
        OP_EMIT: begin
          rcnt      <= rcnt + 32'd1;
          pos       <= 32'd0;
          nws       <= 32'd0;
          hits      <= 4'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_BASE: begin
        for (int j = 0; j < MAX_KMER - 1; j++) begin
          wb[j] <= wb[j+1];
        end
        wb[MAX_KMER-1] <= ub;
      end
      OP_EXTRACT: begin
        for (int j = 0; j < MAX_KMER; j++) begin
          w[j] <= (6'(j) < k_c) ? wb[5'(6'(MAX_KMER) - k_c + 6'(j))] : 8'd0;
        end
      end
      OP_CANON: begin
        if (canon_done && ca > cc) begin
          for (int j = 0; j < MAX_KMER; j++) begin
            if (span[j]) begin
              w[j] <= swp[j];
            end
          end
        end
      end
      OP_H_LEN:     h <= {58'd0, k_c};
      OP_H_SEED:    h <= mres ^ {60'd0, seed};
      OP_X_BLK:     x <= blk;
      OP_X_SHR:     x <= mres ^ (mres >> SHR_R);
      OP_H_XOR:     h <= h ^ mres;
      OP_H_BNEXT:   h <= mres;
      OP_H_TAIL:    h <= h ^ tl;
      OP_H_RES:     h <= mres;
      OP_H_SHR:     h <= h ^ (h >> SHR_R);
      OP_H_RES_SHR: h <= mres ^ (mres >> SHR_R);
      OP_EMIT: begin
        read_id   <= rcnt;
        hit_mask  <= hits;
        unmatched <= hits == 4'd0;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/kbrd_ctrl.sv =====
module kbrd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  input  kbrd_pkg::sts_t sts,
  output kbrd_pkg::cmd_t cmd
);
  import kbrd_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_TRIG    = 5'd1;
  localparam logic [4:0] S_CANON   = 5'd2;
  localparam logic [4:0] S_PART    = 5'd3;
  localparam logic [4:0] S_HLEN    = 5'd4;
  localparam logic [4:0] S_HLEN_W  = 5'd5;
  localparam logic [4:0] S_BLK     = 5'd6;
  localparam logic [4:0] S_B1      = 5'd7;
  localparam logic [4:0] S_B2      = 5'd8;
  localparam logic [4:0] S_B3      = 5'd9;
  localparam logic [4:0] S_TAIL    = 5'd10;
  localparam logic [4:0] S_TAIL_W  = 5'd11;
  localparam logic [4:0] S_FIN     = 5'd12;
  localparam logic [4:0] S_FIN_W   = 5'd13;
  localparam logic [4:0] S_MOD     = 5'd14;
  localparam logic [4:0] S_MOD_W   = 5'd15;
  localparam logic [4:0] S_BIT     = 5'd16;
  localparam logic [4:0] S_END     = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.op     = OP_BASE;
            state_next = S_TRIG;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_TRIG: begin
        if (sts.trig) begin
          cmd.op     = OP_EXTRACT;
          state_next = S_CANON;
        end else begin
          state_next = S_END;
        end
      end
      S_CANON: begin
        cmd.op = OP_CANON;
        if (sts.canon_done) begin
          state_next = S_PART;
        end
      end
      S_PART: begin
        if (sts.part_done) begin
          state_next = S_END;
        end else if (sts.part_hit) begin
          cmd.op = OP_PART_NEXT;
        end else begin
          cmd.op     = OP_SEED_CLR;
          state_next = S_HLEN;
        end
      end
      S_HLEN: begin
        cmd.op        = OP_H_LEN;
        cmd.mul_start = 1'b1;
        state_next    = S_HLEN_W;
      end
      S_HLEN_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_H_SEED;
          state_next = S_BLK;
        end
      end
      S_BLK: begin
        if (sts.blk_more) begin
          cmd.op        = OP_X_BLK;
          cmd.mul_start = 1'b1;
          cmd.mul_src_x = 1'b1;
          state_next    = S_B1;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_B1: begin
        if (sts.mul_done) begin
          cmd.op        = OP_X_SHR;
          cmd.mul_start = 1'b1;
          cmd.mul_src_x = 1'b1;
          state_next    = S_B2;
        end
      end
      S_B2: begin
        if (sts.mul_done) begin
          cmd.op        = OP_H_XOR;
          cmd.mul_start = 1'b1;
          state_next    = S_B3;
        end
      end
      S_B3: begin
        if (sts.mul_done) begin
          cmd.op     = OP_H_BNEXT;
          state_next = S_BLK;
        end
      end
      S_TAIL: begin
        if (sts.rem_nz) begin
          cmd.op        = OP_H_TAIL;
          cmd.mul_start = 1'b1;
          state_next    = S_TAIL_W;
        end else begin
          state_next = S_FIN;
        end
      end
      S_TAIL_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_H_RES;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op        = OP_H_SHR;
        cmd.mul_start = 1'b1;
        state_next    = S_FIN_W;
      end
      S_FIN_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_H_RES_SHR;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op     = OP_MOD_START;
        state_next = S_MOD_W;
      end
      S_MOD_W: begin
        if (sts.mod_done) begin
          cmd.op     = OP_MEM_RD;
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        state_next = S_PART;
        if (!sts.probe_bit) begin
          cmd.op = OP_PART_NEXT;
        end else if (sts.seed_last) begin
          cmd.op = OP_PART_HIT;
        end else begin
          cmd.op     = OP_SEED_NEXT;
          state_next = S_HLEN;
        end
      end
      S_END: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/kbrd_checker.sv =====
module kbrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_id,
  input logic [3:0]  hit_mask,
  input logic        unmatched
);

  logic        seen;
  logic [31:0] last_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= 1'b0;
      last_id <= 32'd0;
    end else if (out_valid && out_ready) begin
      seen    <= 1'b1;
      last_id <= read_id;
    end
  end

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_unmatched: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unmatched == (hit_mask == 4'd0))
    else $error("unmatched flag disagrees with hit mask");

  a_id_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen |-> read_id == last_id + 32'd1)
    else $error("read ids out of order");

endmodule

bind kmer_bloom_read_dispatch kbrd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .read_id   (result.read_id),
  .hit_mask  (result.hit_mask),
  .unmatched (result.unmatched)
);

// ===== dv/kbrd_checker.sv =====
`timescale 1ns / 1ps

module kbrd_tb_checker
  import kbrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  kbrd_in_if                    item_mon,
  kbrd_out_if                   result_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int WORDS_PER_PART = FILTER_BITS / 64;

  typedef logic [7:0] kmer_t [MAX_KMER];

  typedef struct packed {
    logic [31:0] read_id;
    logic [3:0]  hit_mask;
    logic        unmatched;
  } report_t;

  report_t     expected_reports[$];
  logic [63:0] filter_words[int];
  kmer_t       window_q;
  logic [31:0] base_pos;
  logic [31:0] next_start;
  logic [31:0] read_count;
  logic [3:0]  read_hits;
  logic [5:0]  r_kmer_len;
  logic [5:0]  r_step;
  logic [3:0]  r_hashes;
  logic [20:0] r_fbits;
  logic [2:0]  r_parts;

  assign pending = expected_reports.size();

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned lo,
                                            longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] complement(logic [7:0] c);
    case (c)
      "A": return "T";
      "C": return "G";
      "G": return "C";
      "T": return "A";
      default: return "N";
    endcase
  endfunction

  function automatic logic [63:0] murmur_hash(kmer_t key, int len, logic [63:0] seed);
    logic [63:0] h;
    logic [63:0] kw;
    int nblk;
    int rem;
    h = seed ^ (64'(len) * MUL_M);
    nblk = len / 8;
    for (int i = 0; i < nblk; i++) begin
      kw = '0;
      for (int j = 0; j < 8; j++) kw |= 64'(key[i*8+j]) << (8 * j);
      kw = kw * MUL_M;
      kw ^= kw >> SHR_R;
      kw = kw * MUL_M;
      h ^= kw;
      h = h * MUL_M;
    end
    rem = len & 7;
    if (rem != 0) begin
      for (int j = rem; j > 0; j--) h ^= 64'(key[nblk*8+j-1]) << (8 * (j - 1));
      h = h * MUL_M;
    end
    h ^= h >> SHR_R;
    h = h * MUL_M;
    h ^= h >> SHR_R;
    return h;
  endfunction

  // The window flips to its reverse complement when the first position that
  // differs from its mirrored complement compares greater.
  function automatic void canonicalize(inout kmer_t w, input int k);
    int half;
    int p;
    int l;
    int r;
    logic [7:0] tmp;
    half = (k - 1) / 2;
    p = 0;
    while (w[p] == complement(w[k-1-p])) begin
      p++;
      if (p >= half) break;
    end
    if (p + p <= k - 1 && w[p] > complement(w[k-1-p])) begin
      l = p;
      r = k - 1 - p;
      while (l <= r) begin
        tmp = complement(w[r]);
        w[r] = complement(w[l]);
        w[l] = tmp;
        if (r == 0) break;
        l++;
        r--;
      end
    end
  endfunction

  function automatic logic partition_holds(int part, kmer_t w, int k, int nh,
                                           longint unsigned fb);
    longint unsigned idx;
    int key;
    logic [63:0] word;
    for (int s = 0; s < nh; s++) begin
      idx = murmur_hash(w, k, 64'(s)) % fb;
      key = part * WORDS_PER_PART + int'(idx >> 6);
      word = filter_words.exists(key) ? filter_words[key] : 64'd0;
      if (!word[63 - int'(idx & 63)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_beat();
    logic [7:0] b;
    int k;
    int nh;
    int np;
    longint unsigned fb;
    kmer_t w;
    report_t rep;
    if (!item_mon.action) begin
      filter_words[int'(item_mon.partition) * WORDS_PER_PART + int'(item_mon.word_index)] =
        item_mon.word_data;
      return;
    end
    b = item_mon.base;
    if (b >= "a" && b <= "z") b = b - 8'd32;
    for (int i = 0; i < MAX_KMER - 1; i++) window_q[i] = window_q[i+1];
    window_q[MAX_KMER-1] = b;
    base_pos++;
    k = int'(clamp(r_kmer_len, 1, MAX_KMER));
    if (base_pos == next_start + 32'(k)) begin
      nh = int'(clamp(r_hashes, 1, MAX_HASHES));
      np = int'(clamp(r_parts, 1, NUM_PARTS));
      fb = clamp(r_fbits, 1, FILTER_BITS);
      w = window_q;
      for (int i = 0; i < k; i++) w[i] = window_q[MAX_KMER-k+i];
      canonicalize(w, k);
      for (int p = 0; p < np; p++) begin
        if (!read_hits[p] && partition_holds(p, w, k, nh, fb)) read_hits[p] = 1'b1;
      end
      next_start += 32'(clamp(r_step, 1, 32));
    end
    if (item_mon.last_base) begin
      rep.read_id = read_count;
      rep.hit_mask = read_hits;
      rep.unmatched = (read_hits == 4'd0);
      expected_reports = {expected_reports, rep};
      read_count++;
      base_pos = '0;
      next_start = '0;
      read_hits = '0;
      for (int i = 0; i < MAX_KMER; i++) window_q[i] = '0;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      fail_count = 0;
      expected_reports.delete();
      for (int i = 0; i < MAX_KMER; i++) window_q[i] = '0;
      base_pos = '0;
      next_start = '0;
      read_count = '0;
      read_hits = '0;
      r_kmer_len = 6'd25;
      r_step = 6'd1;
      r_hashes = 4'd3;
      r_fbits = 21'd1048576;
      r_parts = 3'd1;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no report pending: read_id %0d", result_mon.read_id);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (result_mon.read_id !== want.read_id) begin
            $error("read_id: expected %0d, actual %0d", want.read_id, result_mon.read_id);
            fail_count++;
          end
          if (result_mon.hit_mask !== want.hit_mask) begin
            $error("hit_mask: expected %h, actual %h", want.hit_mask, result_mon.hit_mask);
            fail_count++;
          end
          if (result_mon.unmatched !== want.unmatched) begin
            $error("unmatched: expected %b, actual %b", want.unmatched, result_mon.unmatched);
            fail_count++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready) predict_beat();
      if (cfg_we) begin
        case (cfg_index)
          CFG_KMER_LEN:    r_kmer_len = cfg_data[5:0];
          CFG_KMER_STEP:   r_step = cfg_data[5:0];
          CFG_NUM_HASHES:  r_hashes = cfg_data[3:0];
          CFG_FILTER_BITS: r_fbits = cfg_data[20:0];
          CFG_NUM_PARTS:   r_parts = cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== dv/kmer_bloom_read_dispatch_tb.sv =====
`timescale 1ns / 1ps

module kmer_bloom_read_dispatch_tb;
  import kbrd_pkg::*;

  // Words 0..SMALL_WORDS-1 of every partition are loaded at the start, and
  // every window is checked with filter_bits at most 64 * SMALL_WORDS, so no
  // probe ever lands on a word that was never loaded.
  localparam int SMALL_WORDS = 128;
  localparam int SMALL_BITS = 64 * SMALL_WORDS;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [31:0] UPPER_BASES = "ACGT";
  localparam logic [31:0] LOWER_BASES = "acgt";

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending;
  int report_beats;

  kbrd_in_if  item_ch ();
  kbrd_out_if result_ch ();

  kmer_bloom_read_dispatch dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kbrd_tb_checker u_tb_checker (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs somewhere.
  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Each partition gets a different bit density, so that some windows hit
  // and others miss.
  function automatic logic [63:0] filter_word(int part);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (part)
      0: return a | b | c;
      1: return a | b;
      2: return a;
      default: return a & b;
    endcase
  endfunction

  // Mostly genuine bases in either case, with some N and the odd raw byte.
  function automatic logic [7:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return UPPER_BASES[8*$urandom_range(0, 3) +: 8];
    if (r < 85) return LOWER_BASES[8*$urandom_range(0, 3) +: 8];
    if (r < 92) return "N";
    return 8'($urandom);
  endfunction

  // One beat on the item channel, after a random gap.
  task automatic send_beat(logic act, logic [1:0] part, logic [13:0] widx,
                           logic [63:0] wdata, logic [7:0] b, logic last);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.partition <= part;
    item_ch.word_index <= widx;
    item_ch.word_data <= wdata;
    item_ch.base <= b;
    item_ch.last_base <= last;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
  endtask

  task automatic load_word(int part, int widx);
    send_beat(1'b0, 2'(part), 14'(widx), filter_word(part), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_base(logic [7:0] b, logic last);
    send_beat(1'b1, 2'($urandom), 14'($urandom), {$urandom, $urandom}, b, last);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_base(s[i], i == s.len() - 1);
  endtask

  // A read of random bases; now and then a load beat lands in the middle,
  // which must leave the read untouched.
  task automatic send_read(int len, inout int count);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        load_word($urandom_range(0, 3), $urandom_range(0, SMALL_WORDS - 1));
        count++;
      end
      send_base(pick_base(), i == len - 1);
      count++;
    end
  endtask

  // Registers are only rewritten once the block has gone quiet.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int klen, int step, int nh, int fbits, int np);
    logic [CFG_IDX_W-1:0] idx[5];
    logic [20:0] val[5];
    idx = '{CFG_KMER_LEN, CFG_KMER_STEP, CFG_NUM_HASHES, CFG_FILTER_BITS, CFG_NUM_PARTS};
    val = '{21'(klen), 21'(step), 21'(nh), 21'(fbits), 21'(np)};
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: a random stall before most beats, none for a run of twenty
  // beats, plus one long hold-off in the middle of a batch of reads, so that a
  // finished read waits and the item channel backs up behind it.
  initial begin
    int gap;
    result_ch.ready <= 1'b0;
    report_beats = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 8);
      if (report_beats == 25) gap = 3000;
      else if (report_beats >= 60 && report_beats < 80) gap = 0;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      report_beats++;
    end
  end

  initial begin
    int count;
    int len;
    int fbits;
    item_ch.valid <= 1'b0;
    item_ch.action <= 1'b0;
    item_ch.partition <= '0;
    item_ch.word_index <= '0;
    item_ch.word_data <= '0;
    item_ch.base <= '0;
    item_ch.last_base <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill the filters before any window can probe them.
    for (int p = 0; p < NUM_PARTS; p++)
      for (int w = 0; w < SMALL_WORDS; w++) load_word(p, w);

    // Reset settings: these reads are shorter than a window.
    send_text("ACG");
    send_base(8'h00, 1'b0);
    load_word(0, 0);
    send_base(8'hFF, 1'b1);

    // 25-base windows with the reset step and hash count.
    configure(25, 1, 3, SMALL_BITS, 1);
    send_text("ACGTACGTTGCAAGGCTTAACCGGTAT");
    send_text("acgtnacgtaaccggttacgatcgat");

    // Length-one windows, where N is its own complement.
    configure(1, 1, 1, 1, 4);
    send_text("N");
    send_text("AT");
    send_text("xgC");

    // Longest windows, widest step and most hashes.
    configure(32, 32, 8, SMALL_BITS, 4);
    send_text("TTTTTTTTTTTTTTTTACGTACGTACGTAAAAAAAAAAAAAAAAAAAAAAAAAAAA");

    // Zero registers saturate to their low bounds.
    configure(0, 0, 0, 0, 0);
    send_text("GATTACA");

    // Oversized registers saturate to their high bounds.
    configure(63, 63, 15, SMALL_BITS, 7);
    send_text("CCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCGGG");
    configure(8, 2, 2, SMALL_BITS, 7);
    send_text("ACGTTGCAacgtNNAC");

    // Random phases with random settings; most reads are long enough to
    // form windows, some are shorter than the window.
    count = 0;
    while (count < RANDOM_ITEMS) begin
      fbits = $urandom_range(1, SMALL_BITS);
      configure($urandom_range(1, 32), $urandom_range(1, 12), $urandom_range(1, 3),
                fbits, $urandom_range(1, 4));
      for (int r = 0; r < 10 && count < RANDOM_ITEMS; r++) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 40);
        send_read(len, count);
      end
    end

    // Let every outstanding report come back, then give the verdict.
    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
